@@ sv/ycra_pkg.sv @@
package ycra_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned WidthW  = 14;
  localparam int unsigned ColW    = 13;
  localparam int unsigned SumW    = 20;

  localparam logic [WidthW-1:0] MaxWidth   = 14'd8192;
  localparam logic [WidthW-1:0] ResetWidth = 14'd1920;

  // register indexes on the configuration port
  localparam logic CFG_OUTPUT_MODE = 1'b0;
  localparam logic CFG_FRAME_WIDTH = 1'b1;

  // output_mode codes
  localparam logic MODE_OPAQUE = 1'b0;
  localparam logic MODE_BANDS  = 1'b1;

  localparam logic signed [SumW-1:0] K_Y     = 20'sd298;
  localparam logic signed [SumW-1:0] K_CB_B  = 20'sd516;
  localparam logic signed [SumW-1:0] K_CB_G  = 20'sd100;
  localparam logic signed [SumW-1:0] K_CR_G  = 20'sd208;
  localparam logic signed [SumW-1:0] K_CR_R  = 20'sd409;
  localparam logic signed [SumW-1:0] ROUND   = 20'sd128;
  localparam logic signed [SumW-1:0] Y_OFS   = 20'sd16;
  localparam logic signed [SumW-1:0] C_OFS   = 20'sd128;

  localparam logic [SampleW-1:0] ALPHA_CLEAR = 8'd0;
  localparam logic [SampleW-1:0] ALPHA_HALF  = 8'd128;
  localparam logic [SampleW-1:0] ALPHA_OPAQUE = 8'd255;

  typedef logic signed [SumW-1:0] sum_t;

  // drop the rounding fraction and clamp to 0..255
  function automatic logic [SampleW-1:0] sat_byte(input sum_t sum);
    logic [SumW-9:0] q;
    begin
      q = sum[SumW-1:8];
      if (sum[SumW-1]) begin
        sat_byte = 8'd0;
      end else if (q > 12'd255) begin
        sat_byte = 8'd255;
      end else begin
        sat_byte = q[SampleW-1:0];
      end
    end
  endfunction

endpackage

@@ sv/ycbcr_to_rgb_alpha_bands.sv @@
// Stages: input register, result register; color math and band compare each fit one stage.
// Throughput: one pixel per cycle while out_tready does not stall the pipeline.
// in_tready drops only while the result register is full and out_tready is low.
// Reset (rst_n, synchronous, active low): pipeline empty, output_mode opaque,
// frame_width 1920, column counter at 0.
module ycbcr_to_rgb_alpha_bands import ycra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // luma[7:0], chroma_blue[15:8], chroma_red[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // blue[7:0], green[15:8], red[23:16], alpha[31:24]
);

  logic              mode_r;
  logic [WidthW-1:0] width_r;
  logic [ColW-1:0]   col_r, col_nxt;

  logic               s1_valid_r;
  logic [SampleW-1:0] s1_y_r, s1_cb_r, s1_cr_r, s1_alpha_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic               s1_ready, in_fire, s1_move;
  logic [WidthW-1:0]  w_eff;
  logic [WidthW:0]    three_x, two_w;
  logic [WidthW-1:0]  x_inc;
  logic [SampleW-1:0] alpha_nxt;

  sum_t ym, dm, em, c_term, b_sum, g_sum, r_sum;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_ready  = !s1_valid_r || !out_valid_r || out_tready;
  assign in_tready = s1_ready;
  assign in_fire   = in_tvalid && s1_ready;

  // saturate the programmed width to 1..8192
  always_comb begin
    if (width_r == '0) begin
      w_eff = 14'd1;
    end else if (width_r > MaxWidth) begin
      w_eff = MaxWidth;
    end else begin
      w_eff = width_r;
    end
  end

  always_comb begin
    three_x = {2'b00, col_r} + {1'b0, col_r, 1'b0};
    two_w   = {w_eff, 1'b0};
    if (mode_r == MODE_OPAQUE) begin
      alpha_nxt = ALPHA_OPAQUE;
    end else if (three_x < {1'b0, w_eff}) begin
      alpha_nxt = ALPHA_CLEAR;
    end else if (three_x < two_w) begin
      alpha_nxt = ALPHA_HALF;
    end else begin
      alpha_nxt = ALPHA_OPAQUE;
    end
    x_inc = {1'b0, col_r} + 14'd1;
    col_nxt = (x_inc >= w_eff) ? '0 : x_inc[ColW-1:0];
  end

  always_comb begin
    ym     = $signed({12'd0, s1_y_r}) - Y_OFS;
    dm     = $signed({12'd0, s1_cb_r}) - C_OFS;
    em     = $signed({12'd0, s1_cr_r}) - C_OFS;
    c_term = K_Y * ym;
    b_sum  = c_term + K_CB_B * dm + ROUND;
    g_sum  = c_term - K_CB_G * dm - K_CR_G * em + ROUND;
    r_sum  = c_term + K_CR_R * em + ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OPAQUE;
      width_r     <= ResetWidth;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OUTPUT_MODE: mode_r  <= cfg_wdata[0];
          CFG_FRAME_WIDTH: width_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        col_r <= col_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload: capture on transaction, hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_y_r     <= in_tdata[7:0];
      s1_cb_r    <= in_tdata[15:8];
      s1_cr_r    <= in_tdata[23:16];
      s1_alpha_r <= alpha_nxt;
    end
    if (s1_move) begin
      out_data_r <= {s1_alpha_r, sat_byte(r_sum), sat_byte(g_sum), sat_byte(b_sum)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
